### rtl/mps_pkg.sv
// shared types, codes and constants of the multilevel process scheduler
// no dependencies
package mps_pkg;

	localparam int TASK_SLOTS_DEF = 64;

	localparam logic [2:0] OP_ADMIT = 3'd0;
	localparam logic [2:0] OP_SET_STATE = 3'd1;
	localparam logic [2:0] OP_SET_QUEUE = 3'd2;
	localparam logic [2:0] OP_SET_PRIO = 3'd3;
	localparam logic [2:0] OP_AGE = 3'd4;
	localparam logic [2:0] OP_PICK = 3'd5;

	localparam logic [2:0] TS_UNUSED = 3'd0;
	localparam logic [2:0] TS_RUNNABLE = 3'd3;
	localparam logic [2:0] TS_RUNNING = 3'd4;
	localparam logic [2:0] TS_ZOMBIE = 3'd5;

	localparam logic [1:0] Q_RR = 2'd0;
	localparam logic [1:0] Q_LCFS = 2'd1;
	localparam logic [1:0] Q_BJF = 2'd2;
	localparam logic [1:0] Q_DEFAULT = 2'd3;

	localparam logic [2:0] RS_OK = 3'd0;
	localparam logic [2:0] RS_NOT_FOUND = 3'd1;
	localparam logic [2:0] RS_FULL = 3'd2;
	localparam logic [2:0] RS_NONE = 3'd3;
	localparam logic [2:0] RS_SAME = 3'd4;

	localparam logic [2:0] CR_PRIO_W = 3'd0;
	localparam logic [2:0] CR_ARR_W = 3'd1;
	localparam logic [2:0] CR_RUN_W = 3'd2;
	localparam logic [2:0] CR_SIZE_W = 3'd3;
	localparam logic [2:0] CR_AGE_LIM = 3'd4;
	localparam logic [2:0] CR_INIT_PRIO = 3'd5;

	// reciprocal of ten for 32-bit operands, shift 35
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	typedef struct packed {
		logic [14:0] pid;
		logic [2:0] status;
		logic [1:0] queue;
	} ctrl_t;

	typedef struct packed {
		logic [31:0] run_stamp;
		logic [31:0] lcfs_stamp;
		logic [7:0] prio;
		logic [31:0] arrival;
		logic [15:0] runs;
		logic [31:0] size;
	} data_t;

	localparam int CTRL_W = $bits(ctrl_t);
	localparam int DATA_W = $bits(data_t);

endpackage

### rtl/mps_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module mps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/multilevel_process_scheduler_core.sv
// multilevel process scheduler: task table in two rams, slot scan sequencer
// depends on mps_pkg and mps_ram
// ops that write a slot scan all slots, drain the pipeline, select, read and write;
// age, failed lookups, admits and picks skip the read and write; an unknown op goes
// straight to the response step; one request in flight, the next is taken the cycle
// after the result is registered, and a stalled result holds the sequencer in ST_RESP
// reset: control table reads as empty through per-slot valid flops, pid counter 1
module multilevel_process_scheduler_core
	import mps_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [2:0] op,
	input logic [14:0] task_pid,
	input logic [2:0] new_state,
	input logic [1:0] target_queue,
	input logic [7:0] new_priority,
	input logic [31:0] now_ticks,
	input logic [31:0] task_size,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [2:0] status,
	output logic [14:0] result_pid,
	output logic [1:0] prior_queue,
	output logic [1:0] picked_level,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [2:0] DRAIN_LAST = 3'd3;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_SEL = 3'd3;
	localparam logic [2:0] ST_RD = 3'd4;
	localparam logic [2:0] ST_WR = 3'd5;
	localparam logic [2:0] ST_RESP = 3'd6;

	// configuration registers
	logic [15:0] prio_w_q, arr_w_q, run_w_q, size_w_q;
	logic [31:0] age_lim_q;
	logic [7:0] init_prio_q;

	// latched request
	logic [2:0] op_q, nst_q;
	logic [14:0] pid_q;
	logic [1:0] tq_q;
	logic [7:0] npri_q;
	logic [31:0] now_q, size_q;

	// sequencer
	logic [2:0] state_q;
	logic [SLOT_W-1:0] addr_q;
	logic [2:0] drain_q;
	logic [SLOT_W-1:0] tgt_q;

	// global scheduler state
	logic [14:0] next_pid_q;
	logic [SLOT_W-1:0] last_rr_q, last_lc_q;
	logic last_lc_vld_q;

	// ram ports and valid flags of the control table
	logic [TASK_SLOTS-1:0] vld_q;
	logic ctrl_we, data_we;
	logic [SLOT_W-1:0] waddr, raddr, rd_addr_q;
	ctrl_t ctrl_wd, ctrl_raw, ctrl_rd;
	data_t data_wd, data_rd;

	// scan pipeline
	logic v_s1;
	logic cand_s2, cand_s3, cand_s4;
	logic [SLOT_W-1:0] addr_s2, addr_s3, addr_s4;
	logic [23:0] p_pri_s2;
	logic [47:0] p_arr_s2, p_size_s2, p_size_s3;
	logic [31:0] p_run_s2;
	logic [28:0] run_div_s3;
	logic [48:0] sum_s3;
	logic [49:0] rank_s4;

	// scan findings
	logic fnd_q;
	logic [SLOT_W-1:0] fnd_slot_q;
	logic rr_hi_f_q, rr_lo_f_q, lc_f_q, stk_hit_q, bj_f_q;
	logic [SLOT_W-1:0] rr_hi_q, rr_lo_q, lc_slot_q, bj_slot_q;
	logic [31:0] lc_max_q;
	logic [49:0] bj_min_q;

	// result being built and the output register
	logic [2:0] res_st_q;
	logic [1:0] res_prior_q, res_lvl_q;
	logic [14:0] res_pid_q;
	logic rsp_valid_q;
	logic [2:0] rsp_st_q;
	logic [14:0] rsp_pid_q;
	logic [1:0] rsp_prior_q, rsp_lvl_q;

	logic req_acc;
	logic s1_runnable, s1_age_hit;
	logic [31:0] waited;
	logic [1:0] tq_eff;
	logic [14:0] pid_inc;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign status = rsp_st_q;
	assign result_pid = rsp_pid_q;
	assign prior_queue = rsp_prior_q;
	assign picked_level = rsp_lvl_q;

	mps_ram #(.WIDTH(CTRL_W), .DEPTH(TASK_SLOTS)) u_ctrl_ram (
		.clk(clk), .we(ctrl_we), .waddr(waddr), .wdata(ctrl_wd),
		.raddr(raddr), .rdata(ctrl_raw)
	);

	mps_ram #(.WIDTH(DATA_W), .DEPTH(TASK_SLOTS)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(waddr), .wdata(data_wd),
		.raddr(raddr), .rdata(data_rd)
	);

	// never written slot reads as unused
	assign ctrl_rd = vld_q[rd_addr_q] ? ctrl_raw : '0;
	assign raddr = (state_q == ST_RD) ? tgt_q : addr_q;

	assign s1_runnable = (ctrl_rd.status == TS_RUNNABLE);
	assign waited = now_q - data_rd.run_stamp;
	assign s1_age_hit = v_s1 && (op_q == OP_AGE) && s1_runnable &&
		(ctrl_rd.queue != Q_RR) && (waited > age_lim_q);

	// default queue follows the pid
	assign tq_eff = (tq_q != Q_DEFAULT) ? tq_q :
		((pid_q == 15'd1 || pid_q == 15'd2) ? Q_RR : Q_LCFS);
	assign pid_inc = next_pid_q + 15'd1;

	// write port: aging writes during the scan, everything else in the write step
	always_comb begin
		ctrl_we = 1'b0;
		data_we = 1'b0;
		waddr = tgt_q;
		ctrl_wd = ctrl_rd;
		data_wd = data_rd;
		if (s1_age_hit) begin
			ctrl_we = 1'b1;
			waddr = rd_addr_q;
			ctrl_wd.queue = Q_RR;
		end else if (state_q == ST_WR) begin
			case (op_q)
				OP_ADMIT: begin
					ctrl_we = 1'b1;
					data_we = 1'b1;
					ctrl_wd.pid = next_pid_q;
					ctrl_wd.status = TS_RUNNABLE;
					ctrl_wd.queue = (next_pid_q == 15'd1 || next_pid_q == 15'd2) ?
						Q_RR : Q_LCFS;
					data_wd.run_stamp = now_q;
					data_wd.lcfs_stamp = now_q;
					data_wd.prio = init_prio_q;
					data_wd.arrival = now_q;
					data_wd.runs = '0;
					data_wd.size = size_q;
				end
				OP_SET_STATE: begin
					// states six and seven leave the slot alone
					if (nst_q <= TS_ZOMBIE) begin
						ctrl_we = 1'b1;
						ctrl_wd.status = nst_q;
						if (nst_q == TS_UNUSED) begin
							ctrl_wd.pid = '0;
						end
					end
				end
				OP_SET_QUEUE: begin
					if (ctrl_rd.queue != tq_eff) begin
						ctrl_we = 1'b1;
						data_we = 1'b1;
						ctrl_wd.queue = tq_eff;
						if (tq_eff == Q_LCFS) begin
							data_wd.lcfs_stamp = now_q;
						end
					end
				end
				OP_SET_PRIO: begin
					data_we = 1'b1;
					data_wd.prio = npri_q;
				end
				OP_PICK: begin
					ctrl_we = 1'b1;
					data_we = 1'b1;
					ctrl_wd.status = TS_RUNNING;
					data_wd.run_stamp = now_q;
					if (data_rd.runs != 16'hFFFF) begin
						data_wd.runs = data_rd.runs + 16'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_w_q <= 16'd256;
			arr_w_q <= 16'd256;
			run_w_q <= 16'd256;
			size_w_q <= 16'd256;
			age_lim_q <= 32'd8000;
			init_prio_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CR_PRIO_W: prio_w_q <= cfg_data[15:0];
				CR_ARR_W: arr_w_q <= cfg_data[15:0];
				CR_RUN_W: run_w_q <= cfg_data[15:0];
				CR_SIZE_W: size_w_q <= cfg_data[15:0];
				CR_AGE_LIM: age_lim_q <= cfg_data;
				CR_INIT_PRIO: init_prio_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// latched request fields
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q <= op;
			pid_q <= task_pid;
			nst_q <= new_state;
			tq_q <= target_queue;
			npri_q <= new_priority;
			now_q <= now_ticks;
			size_q <= task_size;
		end
	end

	// best-job-first rank pipeline, one multiply per operand and stage
	always_ff @(posedge clk) begin
		addr_s2 <= rd_addr_q;
		p_pri_s2 <= 24'(data_rd.prio) * 24'(prio_w_q);
		p_arr_s2 <= 48'(data_rd.arrival) * 48'(arr_w_q);
		p_run_s2 <= 32'(data_rd.runs) * 32'(run_w_q);
		p_size_s2 <= 48'(data_rd.size) * 48'(size_w_q);
		addr_s3 <= addr_s2;
		run_div_s3 <= 29'((64'(p_run_s2) * 64'(RECIP10)) >> 35);
		sum_s3 <= 49'(p_arr_s2) + 49'(p_pri_s2);
		p_size_s3 <= p_size_s2;
		addr_s4 <= addr_s3;
		rank_s4 <= 50'(sum_s3) + 50'(p_size_s3) + 50'(run_div_s3);
	end

	// sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			drain_q <= '0;
			tgt_q <= '0;
			rd_addr_q <= '0;
			vld_q <= '0;
			next_pid_q <= 15'd1;
			last_rr_q <= LAST_SLOT;
			last_lc_q <= '0;
			last_lc_vld_q <= 1'b0;
			v_s1 <= 1'b0;
			cand_s2 <= 1'b0;
			cand_s3 <= 1'b0;
			cand_s4 <= 1'b0;
			fnd_q <= 1'b0;
			fnd_slot_q <= '0;
			rr_hi_f_q <= 1'b0;
			rr_lo_f_q <= 1'b0;
			lc_f_q <= 1'b0;
			stk_hit_q <= 1'b0;
			bj_f_q <= 1'b0;
			rr_hi_q <= '0;
			rr_lo_q <= '0;
			lc_slot_q <= '0;
			bj_slot_q <= '0;
			lc_max_q <= '0;
			bj_min_q <= '0;
			res_st_q <= RS_OK;
			res_prior_q <= '0;
			res_lvl_q <= '0;
			res_pid_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_st_q <= '0;
			rsp_pid_q <= '0;
			rsp_prior_q <= '0;
			rsp_lvl_q <= '0;
		end else begin
			rd_addr_q <= raddr;
			v_s1 <= (state_q == ST_SCAN);
			cand_s2 <= v_s1 && (op_q == OP_PICK) && s1_runnable && (ctrl_rd.queue == Q_BJF);
			cand_s3 <= cand_s2;
			cand_s4 <= cand_s3;
			if (ctrl_we) begin
				vld_q[waddr] <= 1'b1;
			end
			// the response step reloads the output register itself
			if (rsp_valid_q && !rsp_stall && state_q != ST_RESP) begin
				rsp_valid_q <= 1'b0;
			end

			// per-slot decisions in the cycle after the read
			if (v_s1) begin
				case (op_q)
					OP_ADMIT: begin
						if (!fnd_q && ctrl_rd.status == TS_UNUSED) begin
							fnd_q <= 1'b1;
							fnd_slot_q <= rd_addr_q;
						end
					end
					OP_SET_STATE, OP_SET_QUEUE, OP_SET_PRIO: begin
						if (!fnd_q && pid_q != '0 && ctrl_rd.status != TS_UNUSED &&
							ctrl_rd.pid == pid_q) begin
							fnd_q <= 1'b1;
							fnd_slot_q <= rd_addr_q;
						end
					end
					OP_PICK: begin
						if (s1_runnable && ctrl_rd.queue == Q_RR) begin
							if (rd_addr_q > last_rr_q) begin
								if (!rr_hi_f_q) begin
									rr_hi_f_q <= 1'b1;
									rr_hi_q <= rd_addr_q;
								end
							end else if (!rr_lo_f_q) begin
								rr_lo_f_q <= 1'b1;
								rr_lo_q <= rd_addr_q;
							end
						end
						// sticky lcfs slot: queue not checked
						if (s1_runnable && rd_addr_q == last_lc_q) begin
							stk_hit_q <= 1'b1;
						end
						if (s1_runnable && ctrl_rd.queue == Q_LCFS &&
							(!lc_f_q || data_rd.lcfs_stamp >= lc_max_q)) begin
							lc_f_q <= 1'b1;
							lc_slot_q <= rd_addr_q;
							lc_max_q <= data_rd.lcfs_stamp;
						end
					end
					default: begin
					end
				endcase
			end
			if (cand_s4 && (!bj_f_q || rank_s4 < bj_min_q)) begin
				bj_f_q <= 1'b1;
				bj_min_q <= rank_s4;
				bj_slot_q <= addr_s4;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						addr_q <= '0;
						drain_q <= '0;
						fnd_q <= 1'b0;
						rr_hi_f_q <= 1'b0;
						rr_lo_f_q <= 1'b0;
						lc_f_q <= 1'b0;
						stk_hit_q <= 1'b0;
						bj_f_q <= 1'b0;
						res_st_q <= RS_OK;
						res_prior_q <= '0;
						res_lvl_q <= '0;
						res_pid_q <= '0;
						// unknown ops answer zero without touching the table
						state_q <= (op > OP_PICK) ? ST_RESP : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == DRAIN_LAST) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					case (op_q)
						OP_ADMIT: begin
							if (fnd_q) begin
								tgt_q <= fnd_slot_q;
								state_q <= ST_RD;
							end else begin
								res_st_q <= RS_FULL;
								state_q <= ST_RESP;
							end
						end
						OP_SET_STATE, OP_SET_QUEUE, OP_SET_PRIO: begin
							if (fnd_q) begin
								tgt_q <= fnd_slot_q;
								state_q <= ST_RD;
							end else begin
								res_st_q <= RS_NOT_FOUND;
								state_q <= ST_RESP;
							end
						end
						OP_PICK: begin
							if (rr_hi_f_q) begin
								tgt_q <= rr_hi_q;
								res_lvl_q <= Q_RR;
								state_q <= ST_RD;
							end else if (rr_lo_f_q) begin
								tgt_q <= rr_lo_q;
								res_lvl_q <= Q_RR;
								state_q <= ST_RD;
							end else if (last_lc_vld_q && stk_hit_q) begin
								tgt_q <= last_lc_q;
								res_lvl_q <= Q_LCFS;
								state_q <= ST_RD;
							end else if (lc_f_q) begin
								tgt_q <= lc_slot_q;
								res_lvl_q <= Q_LCFS;
								state_q <= ST_RD;
							end else if (bj_f_q) begin
								tgt_q <= bj_slot_q;
								res_lvl_q <= Q_BJF;
								state_q <= ST_RD;
							end else begin
								res_st_q <= RS_NONE;
								state_q <= ST_RESP;
							end
						end
						default: begin
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					state_q <= ST_RESP;
					case (op_q)
						OP_ADMIT: begin
							res_pid_q <= next_pid_q;
							// pid counter skips zero on wrap
							next_pid_q <= (pid_inc == '0) ? 15'd1 : pid_inc;
						end
						OP_SET_QUEUE: begin
							res_prior_q <= ctrl_rd.queue;
							if (ctrl_rd.queue == tq_eff) begin
								res_st_q <= RS_SAME;
							end
						end
						OP_PICK: begin
							res_pid_q <= ctrl_rd.pid;
							if (res_lvl_q == Q_RR) begin
								last_rr_q <= tgt_q;
							end else if (res_lvl_q == Q_LCFS) begin
								last_lc_q <= tgt_q;
								last_lc_vld_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_st_q <= res_st_q;
						rsp_pid_q <= res_pid_q;
						rsp_prior_q <= res_prior_q;
						rsp_lvl_q <= res_lvl_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// table is only touched while a request is being worked on
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ctrl_we && !data_we)
		else $error("table write while idle");

	// payload ram is only written in the write step
	a_data_wr_step: assert property (@(posedge clk) disable iff (!arst_n)
		data_we |-> (state_q == ST_WR))
		else $error("data ram written outside write step");

	// the write step always hands over to the response step
	a_wr_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |=> (state_q == ST_RESP))
		else $error("write step not followed by response");

	// pid counter never holds zero
	a_pid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_pid_q != '0)
		else $error("pid counter reached zero");

	// a picked task always comes from a real level
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_lvl_q != Q_DEFAULT))
		else $error("picked level out of range");
endmodule

### dv/multilevel_process_scheduler_core_test.sv
// testbench of the multilevel process scheduler core: directed and random requests
// checked by a scoreboard class that holds a model of the task table
// depends on mps_pkg and the scheduler core rtl
module multilevel_process_scheduler_core_test;
	import mps_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;

	typedef struct {
		logic [2:0] status;
		logic [14:0] pid;
		logic [1:0] prior;
		logic [1:0] level;
	} answer_t;

	// scoreboard: shadow task table, predicts one answer per request
	class sched_scoreboard;
		logic [14:0] t_pid[SLOTS];
		logic [2:0] t_state[SLOTS];
		logic [1:0] t_queue[SLOTS];
		logic [31:0] t_last[SLOTS];
		logic [31:0] t_stamp[SLOTS];
		logic [7:0] t_prio[SLOTS];
		logic [31:0] t_arr[SLOTS];
		logic [15:0] t_runs[SLOTS];
		logic [31:0] t_size[SLOTS];
		logic [14:0] pid_next;
		int rr_last;
		int lcfs_last;
		bit lcfs_ok;
		logic [15:0] w_prio, w_arr, w_run, w_size;
		logic [31:0] age_lim;
		logic [7:0] prio_init;
		answer_t pending[$];
		int errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				t_pid[i] = 0; t_state[i] = TS_UNUSED; t_queue[i] = Q_RR;
				t_last[i] = 0; t_stamp[i] = 0; t_prio[i] = 0;
				t_arr[i] = 0; t_runs[i] = 0; t_size[i] = 0;
			end
			pid_next = 1; rr_last = SLOTS - 1; lcfs_last = 0; lcfs_ok = 0;
			w_prio = 256; w_arr = 256; w_run = 256; w_size = 256;
			age_lim = 8000; prio_init = 3; errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				CR_PRIO_W: w_prio = val[15:0];
				CR_ARR_W: w_arr = val[15:0];
				CR_RUN_W: w_run = val[15:0];
				CR_SIZE_W: w_size = val[15:0];
				CR_AGE_LIM: age_lim = val;
				CR_INIT_PRIO: prio_init = val[7:0];
				default: ;
			endcase
		endfunction

		function int lookup(logic [14:0] pid);
			if (pid == 0) return -1;
			for (int i = 0; i < SLOTS; i++)
				if (t_state[i] != TS_UNUSED && t_pid[i] == pid) return i;
			return -1;
		endfunction

		function logic [63:0] rank(int i);
			logic [63:0] r;
			r = 64'(t_prio[i]) * 64'(w_prio);
			r += 64'(t_arr[i]) * 64'(w_arr);
			r += (64'(t_runs[i]) * 64'(w_run)) / 10;
			r += 64'(t_size[i]) * 64'(w_size);
			return r;
		endfunction

		function int best_job();
			int b;
			logic [63:0] m, r;
			b = -1; m = 0;
			for (int i = 0; i < SLOTS; i++)
				if (t_state[i] == TS_RUNNABLE && t_queue[i] == Q_BJF) begin
					r = rank(i);
					if (b < 0 || r < m) begin m = r; b = i; end
				end
			return b;
		endfunction

		function int newest_lcfs();
			int b;
			logic [31:0] m;
			b = -1; m = 0;
			if (lcfs_ok && t_state[lcfs_last] == TS_RUNNABLE) return lcfs_last;
			for (int i = 0; i < SLOTS; i++)
				if (t_state[i] == TS_RUNNABLE && t_queue[i] == Q_LCFS &&
						(b < 0 || t_stamp[i] >= m)) begin
					m = t_stamp[i]; b = i;
				end
			return b;
		endfunction

		function int next_rr();
			int s;
			s = rr_last;
			for (int k = 0; k < SLOTS; k++) begin
				s = (s + 1) % SLOTS;
				if (t_state[s] == TS_RUNNABLE && t_queue[s] == Q_RR) return s;
			end
			return -1;
		endfunction

		// note an accepted request and queue its answer
		function void note_request(logic [2:0] op, logic [14:0] pid, logic [2:0] nst,
				logic [1:0] tq, logic [7:0] npri, logic [31:0] now, logic [31:0] sz);
			answer_t a;
			int s;
			a = '{RS_OK, 15'd0, Q_RR, Q_RR};
			case (op)
				OP_ADMIT: begin
					s = -1;
					for (int i = 0; i < SLOTS; i++)
						if (s < 0 && t_state[i] == TS_UNUSED) s = i;
					if (s < 0) a.status = RS_FULL;
					else begin
						a.pid = pid_next;
						pid_next = pid_next + 1;
						if (pid_next == 0) pid_next = 1;
						t_pid[s] = a.pid; t_state[s] = TS_RUNNABLE;
						t_queue[s] = (a.pid == 1 || a.pid == 2) ? Q_RR : Q_LCFS;
						t_prio[s] = prio_init; t_runs[s] = 0; t_size[s] = sz;
						t_arr[s] = now; t_last[s] = now; t_stamp[s] = now;
					end
				end
				OP_SET_STATE: begin
					s = lookup(pid);
					if (s < 0) a.status = RS_NOT_FOUND;
					else if (nst <= TS_ZOMBIE) begin
						t_state[s] = nst;
						if (nst == TS_UNUSED) t_pid[s] = 0;
					end
				end
				OP_SET_QUEUE: begin
					s = lookup(pid);
					if (s < 0) a.status = RS_NOT_FOUND;
					else begin
						if (tq == Q_DEFAULT) tq = (pid == 1 || pid == 2) ? Q_RR : Q_LCFS;
						a.prior = t_queue[s];
						if (a.prior == tq) a.status = RS_SAME;
						else begin
							t_queue[s] = tq;
							if (tq == Q_LCFS) t_stamp[s] = now;
						end
					end
				end
				OP_SET_PRIO: begin
					s = lookup(pid);
					if (s < 0) a.status = RS_NOT_FOUND;
					else t_prio[s] = npri;
				end
				OP_AGE: begin
					for (int i = 0; i < SLOTS; i++)
						if (t_state[i] == TS_RUNNABLE && t_queue[i] != Q_RR &&
								32'(now - t_last[i]) > age_lim)
							t_queue[i] = Q_RR;
				end
				OP_PICK: begin
					s = next_rr();
					if (s >= 0) begin rr_last = s; a.level = Q_RR; end
					else begin
						s = newest_lcfs();
						if (s >= 0) begin
							lcfs_last = s; lcfs_ok = 1; a.level = Q_LCFS;
						end else begin
							s = best_job(); a.level = Q_BJF;
						end
					end
					if (s < 0) begin a.status = RS_NONE; a.level = Q_RR; end
					else begin
						a.pid = t_pid[s]; t_state[s] = TS_RUNNING; t_last[s] = now;
						if (t_runs[s] != 16'hFFFF) t_runs[s]++;
					end
				end
				default: ;
			endcase
			pending.push_back(a);
		endfunction

		function void check_answer(answer_t got);
			answer_t e;
			if (pending.size() == 0) begin
				$error("answer with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status expected %0d got %0d", e.status, got.status); errors++;
			end
			if (got.pid !== e.pid) begin
				$error("result_pid expected %0d got %0d", e.pid, got.pid); errors++;
			end
			if (got.prior !== e.prior) begin
				$error("prior_queue expected %0d got %0d", e.prior, got.prior); errors++;
			end
			if (got.level !== e.level) begin
				$error("picked_level expected %0d got %0d", e.level, got.level); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	logic [2:0] op = 0;
	logic [14:0] task_pid = 0;
	logic [2:0] new_state = 0;
	logic [1:0] target_queue = 0;
	logic [7:0] new_priority = 0;
	logic [31:0] now_ticks = 0;
	logic [31:0] task_size = 0;
	logic rsp_valid;
	logic rsp_stall = 0;
	logic [2:0] status;
	logic [14:0] result_pid;
	logic [1:0] prior_queue;
	logic [1:0] picked_level;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	sched_scoreboard sb = new();
	int idle_pct = 0;	// sender gap odds per cycle
	int stall_pct = 0;	// receiver stall odds per cycle
	logic [31:0] clock_ticks = 0;	// advancing tick base for stimulus
	int admitted_top = 0;	// highest pid handed out so far, for pid choice

	multilevel_process_scheduler_core u_dut (.*);

	always #1 clk = ~clk;

	// receiver side: random stall, check on each accepted answer
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_answer('{status, result_pid, prior_queue, picked_level});
	end

	// one request: optional gap, then hold until accepted; valid is dropped by
	// the next gap or by drain
	task automatic send(logic [2:0] o, logic [14:0] p, logic [2:0] st, logic [1:0] q,
			logic [7:0] pr, logic [31:0] now, logic [31:0] sz);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 0;
			@(negedge clk);
		end
		req_valid <= 1; op <= o; task_pid <= p; new_state <= st;
		target_queue <= q; new_priority <= pr; now_ticks <= now; task_size <= sz;
		do @(posedge clk); while (req_stall);
		sb.note_request(o, p, st, q, pr, now, sz);
		if (o == OP_ADMIT && sb.pending[$].status == RS_OK)
			admitted_top = sb.pending[$].pid;
		@(negedge clk);
	endtask

	// valid is dropped by the caller after the last write
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// wait for all answers, then let the scan finish before touching registers
	task automatic drain();
		req_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SLOTS + 16) @(negedge clk);
	endtask

	// a random request, mostly well formed against pids that exist
	task automatic random_request();
		logic [2:0] o;
		logic [14:0] p;
		int r;
		r = $urandom_range(99);
		if (r < 22) o = OP_ADMIT;
		else if (r < 40) o = OP_SET_STATE;
		else if (r < 55) o = OP_SET_QUEUE;
		else if (r < 65) o = OP_SET_PRIO;
		else if (r < 72) o = OP_AGE;
		else if (r < 98) o = OP_PICK;
		else o = 3'($urandom_range(7, 6));
		if ($urandom_range(9) < 8 && admitted_top > 0)
			p = 15'($urandom_range(admitted_top, admitted_top > 80 ? admitted_top - 80 : 0));
		else p = 15'($urandom);
		// ticks mostly creep, sometimes jump so aging and wrap both occur
		if ($urandom_range(9) == 0) clock_ticks = $urandom;
		else clock_ticks = clock_ticks + $urandom_range(3000);
		send(o, p, 3'($urandom_range(9) < 7 ? $urandom_range(4, 2) : $urandom),
			2'($urandom), 8'($urandom), clock_ticks,
			$urandom_range(3) == 0 ? $urandom : $urandom_range(50000));
	endtask

	initial begin
		#20000000;
		$display("FAIL multilevel_process_scheduler_core");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: empty pick, unknown pids, admits, each op and corner case
		send(OP_PICK, 0, 0, 0, 0, 0, 0);
		send(OP_SET_STATE, 0, TS_RUNNABLE, 0, 0, 0, 0);
		send(OP_SET_PRIO, 15'h7FFF, 0, 0, 8'hFF, 0, 0);
		send(OP_ADMIT, 0, 0, 0, 0, 32'd100, 32'hFFFF_FFFF);
		send(OP_ADMIT, 0, 0, 0, 0, 32'd200, 32'd0);
		send(OP_ADMIT, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'd4096);
		send(OP_ADMIT, 0, 0, 0, 0, 32'd300, 32'd10);
		send(OP_SET_QUEUE, 3, 0, Q_LCFS, 0, 400, 0);
		send(OP_SET_QUEUE, 3, 0, Q_DEFAULT, 0, 400, 0);
		send(OP_SET_QUEUE, 4, 0, Q_BJF, 0, 500, 0);
		send(OP_SET_QUEUE, 1, 0, Q_DEFAULT, 0, 500, 0);
		send(OP_SET_PRIO, 4, 0, 0, 8'd0, 0, 0);
		send(OP_SET_STATE, 2, 3'd7, 0, 0, 0, 0);
		send(OP_PICK, 0, 0, 0, 0, 600, 0);
		send(OP_PICK, 0, 0, 0, 0, 700, 0);
		send(OP_PICK, 0, 0, 0, 0, 800, 0);
		send(OP_PICK, 0, 0, 0, 0, 900, 0);
		send(OP_PICK, 0, 0, 0, 0, 950, 0);
		send(OP_SET_STATE, 3, TS_RUNNABLE, 0, 0, 0, 0);
		send(OP_AGE, 0, 0, 0, 0, 32'd20000, 0);
		send(OP_SET_STATE, 1, TS_UNUSED, 0, 0, 0, 0);
		send(3'd6, 15'h7FFF, 3'd7, 2'd3, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(3'd7, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < SLOTS + 1; i++) send(OP_ADMIT, 0, 0, 0, 0, 1000, i);
		drain();

		// random phases over register settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 51; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 51; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			write_reg(CR_PRIO_W, ph == 1 ? 0 : (ph == 2 ? 32'hFFFF : $urandom_range(65535)));
			write_reg(CR_ARR_W, ph == 1 ? 0 : (ph == 3 ? 32'hFFFF : $urandom_range(65535)));
			write_reg(CR_RUN_W, ph == 1 ? 0 : (ph == 4 ? 32'hFFFF : $urandom_range(65535)));
			write_reg(CR_SIZE_W, ph == 1 ? 0 : (ph == 5 ? 32'hFFFF : $urandom_range(65535)));
			write_reg(CR_AGE_LIM, ph == 1 ? 0 : (ph == 2 ? 32'hFFFF_FFFF :
				$urandom_range(20000)));
			write_reg(CR_INIT_PRIO, ph == 1 ? 0 : (ph == 2 ? 255 : $urandom_range(255)));
			cfg_valid <= 0;
			for (int n = 0; n < 235; n++) random_request();
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS multilevel_process_scheduler_core");
		else
			$display("FAIL multilevel_process_scheduler_core");
		$finish;
	end

endmodule

### files.f
rtl/mps_pkg.sv
rtl/mps_ram.sv
rtl/multilevel_process_scheduler_core.sv
dv/multilevel_process_scheduler_core_test.sv
